>>> rtl/sta_pkg.sv
// package for the swizzled texel address unit
// storage mode codes, fixed widths and the block placement tables; no dependencies
package sta_pkg;

    localparam int WIDTH_BITS = 12;
    localparam int ADDR_BITS  = 24;
    localparam int PAGE_BITS  = 14;

    localparam logic [WIDTH_BITS-1:0] BUFFER_WIDTH_RESET = 12'd64;

    typedef enum logic [2:0] {
        MODE_32     = 3'd0,
        MODE_16     = 3'd1,
        MODE_8      = 3'd2,
        MODE_4      = 3'd3,
        MODE_LINEAR = 3'd4
    } mode_t;

    // block placement for pages eight blocks wide (32-bit and 8-bit modes)
    localparam logic [4:0] PERM_WIDE [32] = '{
        5'd0,  5'd1,  5'd4,  5'd5,  5'd16, 5'd17, 5'd20, 5'd21,
        5'd2,  5'd3,  5'd6,  5'd7,  5'd18, 5'd19, 5'd22, 5'd23,
        5'd8,  5'd9,  5'd12, 5'd13, 5'd24, 5'd25, 5'd28, 5'd29,
        5'd10, 5'd11, 5'd14, 5'd15, 5'd26, 5'd27, 5'd30, 5'd31
    };

    // block placement for pages four blocks wide (16-bit and 4-bit modes)
    localparam logic [4:0] PERM_TALL [32] = '{
        5'd0,  5'd2,  5'd8,  5'd10, 5'd1,  5'd3,  5'd9,  5'd11,
        5'd4,  5'd6,  5'd12, 5'd14, 5'd5,  5'd7,  5'd13, 5'd15,
        5'd16, 5'd18, 5'd24, 5'd26, 5'd17, 5'd19, 5'd25, 5'd27,
        5'd20, 5'd22, 5'd28, 5'd30, 5'd21, 5'd23, 5'd29, 5'd31
    };

endpackage

>>> rtl/swizzled_texel_address_unit.sv
// top level of the swizzled texel address unit
// four stage address pipeline; depends on sta_pkg
//
// channel   ports                                      handshake
// -------   -----------------------------------------  ---------------------------
// command   coord_x, coord_y, pixel_mode               start high and busy low
// result    byte_address                               done strobe, one cycle
// config    width_data                                 width_we, no wait
//
// one transaction enters every cycle; busy never rises
// the result strobes once start has passed the four register stages
// (decode and block lookup, page row multiply, page add, final shift and merge)
// rst_n clears the valid bits and sets the buffer width to 64
// the receiver cannot stall, so nothing in the pipeline ever holds
module swizzled_texel_address_unit #(
    parameter int COORD_BITS = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [COORD_BITS-1:0]         coord_x,
    input  logic [COORD_BITS-1:0]         coord_y,
    input  logic [2:0]                    pixel_mode,
    output logic                          done,
    output logic [sta_pkg::ADDR_BITS-1:0] byte_address,
    input  logic                          width_we,
    input  logic [sta_pkg::WIDTH_BITS-1:0] width_data
);

    localparam int EXT_W  = (COORD_BITS < 8) ? 8 : COORD_BITS;
    localparam int PROD_W = EXT_W + sta_pkg::WIDTH_BITS;
    localparam int SUM_W  = PROD_W + 1;
    localparam int IDX_W  = sta_pkg::ADDR_BITS + 1;

    logic [sta_pkg::WIDTH_BITS-1:0] width_reg;

    logic [EXT_W-1:0] x_ext;
    logic [EXT_W-1:0] y_ext;
    logic [sta_pkg::WIDTH_BITS:0] ppr_sum;
    logic [4:0]       slot;
    logic [4:0]       blk;

    logic                            s1_valid_reg;
    sta_pkg::mode_t                  s1_mode_reg, s1_mode_next;
    logic [EXT_W-1:0]                s1_a_reg, s1_a_next;
    logic [sta_pkg::WIDTH_BITS-1:0]  s1_b_reg, s1_b_next;
    logic [EXT_W-1:0]                s1_add_reg, s1_add_next;
    logic [sta_pkg::PAGE_BITS-1:0]   s1_page_reg, s1_page_next;

    logic                            s2_valid_reg;
    sta_pkg::mode_t                  s2_mode_reg;
    logic [PROD_W-1:0]               s2_prod_reg;
    logic [EXT_W-1:0]                s2_add_reg;
    logic [sta_pkg::PAGE_BITS-1:0]   s2_page_reg;

    logic                            s3_valid_reg;
    sta_pkg::mode_t                  s3_mode_reg;
    logic [SUM_W-1:0]                s3_sum_reg;
    logic [sta_pkg::PAGE_BITS-1:0]   s3_page_reg;

    logic                            s4_valid_reg;
    logic [sta_pkg::ADDR_BITS-1:0]   s4_addr_reg, s4_addr_next;

    logic [IDX_W-1:0] sum_ext;
    logic [IDX_W-1:0] texel_idx;

    assign busy         = 1'b0;
    assign done         = s4_valid_reg;
    assign byte_address = s4_addr_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg <= sta_pkg::BUFFER_WIDTH_RESET;
        end
        else if (width_we) begin
            width_reg <= width_data;
        end
    end

    // stage 1: mode decode, page coordinates and in-page offset
    assign x_ext = EXT_W'(coord_x);
    assign y_ext = EXT_W'(coord_y);

    always_comb begin
        s1_mode_next = sta_pkg::MODE_LINEAR;
        s1_a_next    = y_ext;
        s1_b_next    = width_reg;
        s1_add_next  = x_ext;
        s1_page_next = '0;
        ppr_sum      = '0;
        slot         = '0;
        blk          = '0;
        case (pixel_mode)
            sta_pkg::MODE_32: begin
                s1_mode_next = sta_pkg::MODE_32;
                ppr_sum      = {1'b0, width_reg} + 13'd63;
                s1_a_next    = y_ext >> 5;
                s1_b_next    = sta_pkg::WIDTH_BITS'(ppr_sum >> 6);
                s1_add_next  = x_ext >> 6;
                slot         = {y_ext[4:3], x_ext[5:3]};
                blk          = sta_pkg::PERM_WIDE[slot];
                s1_page_next = sta_pkg::PAGE_BITS'({blk, y_ext[2:0], x_ext[2:0]});
            end
            sta_pkg::MODE_16: begin
                s1_mode_next = sta_pkg::MODE_16;
                ppr_sum      = {1'b0, width_reg} + 13'd63;
                s1_a_next    = y_ext >> 6;
                s1_b_next    = sta_pkg::WIDTH_BITS'(ppr_sum >> 6);
                s1_add_next  = x_ext >> 6;
                slot         = {y_ext[5:3], x_ext[5:4]};
                blk          = sta_pkg::PERM_TALL[slot];
                s1_page_next = sta_pkg::PAGE_BITS'({blk, y_ext[2:0], x_ext[3:0]});
            end
            sta_pkg::MODE_8: begin
                s1_mode_next = sta_pkg::MODE_8;
                ppr_sum      = {1'b0, width_reg} + 13'd127;
                s1_a_next    = y_ext >> 6;
                s1_b_next    = sta_pkg::WIDTH_BITS'(ppr_sum >> 7);
                s1_add_next  = x_ext >> 7;
                slot         = {y_ext[5:4], x_ext[6:4]};
                blk          = sta_pkg::PERM_WIDE[slot];
                s1_page_next = sta_pkg::PAGE_BITS'({blk, y_ext[3:0], x_ext[3:0]});
            end
            sta_pkg::MODE_4: begin
                s1_mode_next = sta_pkg::MODE_4;
                ppr_sum      = {1'b0, width_reg} + 13'd127;
                s1_a_next    = y_ext >> 7;
                s1_b_next    = sta_pkg::WIDTH_BITS'(ppr_sum >> 7);
                s1_add_next  = x_ext >> 7;
                slot         = {y_ext[6:4], x_ext[6:5]};
                blk          = sta_pkg::PERM_TALL[slot];
                s1_page_next = {blk, y_ext[3:0], x_ext[4:0]};
            end
            default: begin
                // unused codes fall back to the linear layout
                s1_mode_next = sta_pkg::MODE_LINEAR;
            end
        endcase
    end

    // stage 4: scale the page number to texels, merge offset, apply texel size
    assign sum_ext = IDX_W'(s3_sum_reg);

    always_comb begin
        texel_idx    = '0;
        s4_addr_next = '0;
        case (s3_mode_reg)
            sta_pkg::MODE_32: begin
                texel_idx    = (sum_ext << 11) + IDX_W'(s3_page_reg);
                s4_addr_next = sta_pkg::ADDR_BITS'(texel_idx << 2);
            end
            sta_pkg::MODE_16: begin
                texel_idx    = (sum_ext << 12) + IDX_W'(s3_page_reg);
                s4_addr_next = sta_pkg::ADDR_BITS'(texel_idx << 1);
            end
            sta_pkg::MODE_8: begin
                texel_idx    = (sum_ext << 13) + IDX_W'(s3_page_reg);
                s4_addr_next = sta_pkg::ADDR_BITS'(texel_idx);
            end
            sta_pkg::MODE_4: begin
                // two texels share one byte
                texel_idx    = (sum_ext << 14) + IDX_W'(s3_page_reg);
                s4_addr_next = sta_pkg::ADDR_BITS'(texel_idx >> 1);
            end
            default: begin
                s4_addr_next = sta_pkg::ADDR_BITS'(sum_ext << 2);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_mode_reg <= s1_mode_next;
        s1_a_reg    <= s1_a_next;
        s1_b_reg    <= s1_b_next;
        s1_add_reg  <= s1_add_next;
        s1_page_reg <= s1_page_next;

        // stage 2: page row times pages per row, or y times pitch
        s2_mode_reg <= s1_mode_reg;
        s2_prod_reg <= PROD_W'(s1_a_reg) * PROD_W'(s1_b_reg);
        s2_add_reg  <= s1_add_reg;
        s2_page_reg <= s1_page_reg;

        // stage 3: add page column, or x in the linear layout
        s3_mode_reg <= s2_mode_reg;
        s3_sum_reg  <= SUM_W'(s2_prod_reg) + SUM_W'(s2_add_reg);
        s3_page_reg <= s2_page_reg;

        s4_addr_reg <= s4_addr_next;
    end

endmodule

>>> tb/testbench.sv
// self-checking testbench for swizzled_texel_address_unit: directed and random texel commands
// checked against an in-bench address predictor with its own block placement tables
// depends on sta_pkg and the unit's top level
module testbench;

    localparam int LATENCY     = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // block order inside one page, eight blocks per row and four blocks per row
    localparam logic [4:0] WIDE_BLOCK_ORDER [32] = '{
        5'd0,  5'd1,  5'd4,  5'd5,  5'd16, 5'd17, 5'd20, 5'd21,
        5'd2,  5'd3,  5'd6,  5'd7,  5'd18, 5'd19, 5'd22, 5'd23,
        5'd8,  5'd9,  5'd12, 5'd13, 5'd24, 5'd25, 5'd28, 5'd29,
        5'd10, 5'd11, 5'd14, 5'd15, 5'd26, 5'd27, 5'd30, 5'd31
    };
    localparam logic [4:0] TALL_BLOCK_ORDER [32] = '{
        5'd0,  5'd2,  5'd8,  5'd10, 5'd1,  5'd3,  5'd9,  5'd11,
        5'd4,  5'd6,  5'd12, 5'd14, 5'd5,  5'd7,  5'd13, 5'd15,
        5'd16, 5'd18, 5'd24, 5'd26, 5'd17, 5'd19, 5'd25, 5'd27,
        5'd20, 5'd22, 5'd28, 5'd30, 5'd21, 5'd23, 5'd29, 5'd31
    };

    typedef struct {
        logic [10:0]                   x;
        logic [10:0]                   y;
        logic [2:0]                    mode;
        logic [sta_pkg::ADDR_BITS-1:0] addr;
    } texel_expect_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [10:0]                    coord_x;
    logic [10:0]                    coord_y;
    logic [2:0]                     pixel_mode;
    logic                           done;
    logic [sta_pkg::ADDR_BITS-1:0]  byte_address;
    logic                           width_we;
    logic [sta_pkg::WIDTH_BITS-1:0] width_data;

    texel_expect_t                  pending_addrs[$];
    logic [sta_pkg::WIDTH_BITS-1:0] width_model;
    int                             error_count;
    int                             cycle_count;
    bit                             gaps_enabled;

    swizzled_texel_address_unit #(
        .COORD_BITS(11)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .pixel_mode  (pixel_mode),
        .done        (done),
        .byte_address(byte_address),
        .width_we    (width_we),
        .width_data  (width_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned tiled_texel(longint unsigned x, longint unsigned y,
                                                    int pw, int ph, int bw, int bh,
                                                    bit tall, longint unsigned width);
        longint unsigned pages_per_row;
        longint unsigned page;
        longint unsigned ox;
        longint unsigned oy;
        longint unsigned slot;
        longint unsigned blk;
        pages_per_row = (width + ((64'd1 << pw) - 1)) >> pw;
        page = (x >> pw) + (y >> ph) * pages_per_row;
        ox = x & ((64'd1 << pw) - 1);
        oy = y & ((64'd1 << ph) - 1);
        slot = (((oy >> bh) << (pw - bw)) + (ox >> bw)) & 64'd31;
        blk = tall ? TALL_BLOCK_ORDER[slot] : WIDE_BLOCK_ORDER[slot];
        return (page << (pw + ph)) + (blk << (bw + bh))
               + ((oy & ((64'd1 << bh) - 1)) << bw) + (ox & ((64'd1 << bw) - 1));
    endfunction

    function automatic logic [sta_pkg::ADDR_BITS-1:0] texel_byte_address(
        logic [10:0] x, logic [10:0] y, logic [2:0] mode,
        logic [sta_pkg::WIDTH_BITS-1:0] width);
        longint unsigned addr;
        case (mode)
            sta_pkg::MODE_32: addr = tiled_texel(x, y, 6, 5, 3, 3, 1'b0, width) << 2;
            sta_pkg::MODE_16: addr = tiled_texel(x, y, 6, 6, 4, 3, 1'b1, width) << 1;
            sta_pkg::MODE_8:  addr = tiled_texel(x, y, 7, 6, 4, 4, 1'b0, width);
            sta_pkg::MODE_4:  addr = tiled_texel(x, y, 7, 7, 5, 4, 1'b1, width) >> 1;
            // linear and the unused codes above it
            default: addr = ((longint'(y) * longint'(width)) + longint'(x)) << 2;
        endcase
        return addr[sta_pkg::ADDR_BITS-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_enabled || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // called and left at a rising edge
    task automatic send_texel(logic [10:0] x, logic [10:0] y, logic [2:0] mode);
        texel_expect_t e;
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        coord_x    <= x;
        coord_y    <= y;
        pixel_mode <= mode;
        do @(negedge clk); while (busy);
        @(posedge clk);
        e.x    = x;
        e.y    = y;
        e.mode = mode;
        e.addr = texel_byte_address(x, y, mode, width_model);
        pending_addrs.insert(pending_addrs.size(), e);
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_addrs.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_buffer_width(logic [sta_pkg::WIDTH_BITS-1:0] value);
        drain_pipeline();
        width_we   <= 1'b1;
        width_data <= value;
        @(posedge clk);
        width_we    <= 1'b0;
        width_model = value;
    endtask

    task automatic test_reset_width();
        logic [2:0] m;
        for (int i = 0; i < 8; i++)
        begin
            m = i[2:0];
            send_texel(11'd2047, 11'd2047, m);
        end
        send_texel(11'd0, 11'd0, sta_pkg::MODE_32);
    endtask

    task automatic test_odd_texel_pair();
        send_texel(11'd4, 11'd7, sta_pkg::MODE_4);
        send_texel(11'd5, 11'd7, sta_pkg::MODE_4);
    endtask

    task automatic test_width_extremes();
        write_buffer_width(12'd1);
        send_texel(11'd2047, 11'd2047, sta_pkg::MODE_32);
        send_texel(11'd2047, 11'd2047, sta_pkg::MODE_LINEAR);
        write_buffer_width(12'd2048);
        send_texel(11'd2047, 11'd2047, sta_pkg::MODE_8);
        send_texel(11'd2047, 11'd2047, sta_pkg::MODE_LINEAR);
    endtask

    // zero width: only the page column counts, linear gives x*4
    task automatic test_zero_width();
        write_buffer_width(12'd0);
        send_texel(11'd2047, 11'd2047, sta_pkg::MODE_16);
        send_texel(11'd2047, 11'd5, sta_pkg::MODE_LINEAR);
        send_texel(11'd130, 11'd200, sta_pkg::MODE_4);
    endtask

    task automatic test_address_wrap();
        write_buffer_width(12'hFFF);
        send_texel(11'd2047, 11'd2047, sta_pkg::MODE_LINEAR);
        send_texel(11'd2047, 11'd2047, 3'd7);
    endtask

    task automatic test_random_traffic();
        logic [sta_pkg::WIDTH_BITS-1:0] w;
        logic [10:0] x;
        logic [10:0] y;
        logic [2:0]  m;
        int burst;
        int r;
        int sent;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       w = 12'd1;
                1:       w = 12'd2048;
                2:       w = 12'hFFF;
                3:       w = 12'd0;
                4:       w = sta_pkg::WIDTH_BITS'($urandom_range(0, 4095));
                default: w = sta_pkg::WIDTH_BITS'($urandom_range(1, 2048));
            endcase
            write_buffer_width(w);
            gaps_enabled = (phase % 3) != 0;
            sent = 0;
            while (sent < 195)
            begin
                // scanline bursts: one mode, consecutive x
                r = $urandom_range(0, 15);
                m = (r < 12) ? 3'(r % 5) : 3'(r - 8);
                if ($urandom_range(0, 3) == 0)
                begin
                    x = 11'($urandom_range(0, 255));
                    y = 11'($urandom_range(0, 255));
                end
                else
                begin
                    x = 11'($urandom_range(0, 2047));
                    y = 11'($urandom_range(0, 2047));
                end
                burst = $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < 195; k++)
                begin
                    send_texel(x, y, m);
                    x = x + 11'd1;
                    sent++;
                end
            end
        end
        gaps_enabled = 1'b1;
    endtask

    always @(negedge clk)
    begin : check_result
        texel_expect_t e;
        if (rst_n && done)
        begin
            if (pending_addrs.size() == 0)
                report_mismatch($sformatf("unexpected result 0x%06h", byte_address));
            else
            begin
                e = pending_addrs.pop_front();
                if (byte_address !== e.addr)
                    report_mismatch($sformatf("x=%0d y=%0d mode=%0d: got 0x%06h want 0x%06h",
                                              e.x, e.y, e.mode, byte_address, e.addr));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        gaps_enabled = 1'b1;
        width_model  = sta_pkg::BUFFER_WIDTH_RESET;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        coord_x    <= '0;
        coord_y    <= '0;
        pixel_mode <= sta_pkg::MODE_32;
        width_we   <= 1'b0;
        width_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_width();
        test_odd_texel_pair();
        test_width_extremes();
        test_zero_width();
        test_address_wrap();
        test_random_traffic();

        drain_pipeline();
        if (pending_addrs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_addrs.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
